/* sv/lpe_pkg.sv */
// -----------------------------------------------------------------------------
// lpe_pkg
// shared types and constants for the led pwm bit encoder
// -----------------------------------------------------------------------------
package lpe_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int COLOR_W           = 24;
   localparam int BITS_PER_PIXEL    = 24;
   localparam int TAIL_MAX          = 64;
   localparam int CNT_W             = $clog2(TAIL_MAX);
   localparam int QUEUE_DEPTH       = 4;
   localparam int QCW               = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ONE_WIDTH_RST   = 8'd17;
   localparam logic [7:0] ZERO_WIDTH_RST  = 8'd9;
   localparam logic [6:0] TAIL_LENGTH_RST = 7'd42;

   // request commands
   localparam logic [1:0] CMD_WRITE     = 2'd0;
   localparam logic [1:0] CMD_PIXEL     = 2'd1;
   localparam logic [1:0] CMD_END_FRAME = 2'd2;

   // csr register indexes
   localparam logic [1:0] REG_ONE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_ZERO_WIDTH  = 2'd1;
   localparam logic [1:0] REG_TAIL_LENGTH = 2'd2;

   typedef struct packed {
      logic               tail;
      logic [COLOR_W-1:0] color;
   } q_entry_type;

endpackage

/* sv/lpe_ram.sv */
// -----------------------------------------------------------------------------
// lpe_ram
// generic single write port ram with registered read
// -----------------------------------------------------------------------------
module lpe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lpe_front.sv */
// -----------------------------------------------------------------------------
// lpe_front
// accepts requests, keeps the palette and queues pixel and tail jobs
// -----------------------------------------------------------------------------
module lpe_front #(
   parameter int PALETTE_DEPTH = lpe_pkg::PALETTE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_command,
   input  logic [7:0]                req_index,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [lpe_pkg::QCW-1:0]   q_count,
   output logic                      push,
   output lpe_pkg::q_entry_type      push_entry
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   logic                        clr_active_ff, clr_active_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_tail_ff, s1_tail_in;
   logic                        s1_hit_ff, s1_hit_in;
   logic [lpe_pkg::QCW:0]       used;
   logic                        room;
   logic                        accept;
   logic                        in_range;
   logic [AW-1:0]               addr;
   logic                        is_write, is_pixel, is_end;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [lpe_pkg::COLOR_W-1:0] ram_wr_data;
   logic                        ram_rd_en;
   logic [lpe_pkg::COLOR_W-1:0] ram_rd_data;

   // an accepted job waits in the s1 register before it reaches the queue, so count it as taken
   assign used = {1'b0, q_count} + (lpe_pkg::QCW + 1)'(s1_valid_ff);
   assign room = used < (lpe_pkg::QCW + 1)'(lpe_pkg::QUEUE_DEPTH);

   assign req_stall = clr_active_ff | ~room;
   assign accept    = req_valid & ~req_stall;

   assign in_range = 32'(req_index) < PALETTE_DEPTH;
   assign addr     = AW'(req_index);

   always_comb begin
      is_write = 1'b0;
      is_pixel = 1'b0;
      is_end   = 1'b0;
      case (req_command)
         lpe_pkg::CMD_WRITE:     is_write = 1'b1;
         lpe_pkg::CMD_PIXEL:     is_pixel = 1'b1;
         lpe_pkg::CMD_END_FRAME: is_end   = 1'b1;
         default: begin
         end
      endcase
   end

   // clearing pass owns the write port after reset
   assign ram_wr_en   = clr_active_ff | (accept & is_write & in_range);
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : addr;
   assign ram_wr_data = clr_active_ff ? '0 : {req_red, req_green, req_blue};
   assign ram_rd_en   = accept & is_pixel;

   lpe_ram #(
      .WIDTH (lpe_pkg::COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(PALETTE_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   assign s1_valid_in = accept & (is_pixel | is_end);
   assign s1_tail_in  = is_end;
   assign s1_hit_in   = in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tail_ff <= s1_tail_in;
      s1_hit_ff  <= s1_hit_in;
   end

   assign push       = s1_valid_ff;
   assign push_entry = {s1_tail_ff, ((~s1_tail_ff & s1_hit_ff) ? ram_rd_data
                                                              : lpe_pkg::COLOR_W'(0))};

   a_clear_covers_all: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_active_ff) |-> $past(clr_addr_ff) == AW'(PALETTE_DEPTH - 1))
      else $error("clearing pass ended before the last palette entry");

endmodule

/* sv/lpe_queue.sv */
// -----------------------------------------------------------------------------
// lpe_queue
// short job queue between the front and the bit sequencer
// -----------------------------------------------------------------------------
module lpe_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lpe_pkg::q_entry_type    push_entry,
   input  logic                    pop,
   output logic                    head_valid,
   output lpe_pkg::q_entry_type    head_entry,
   output logic [lpe_pkg::QCW-1:0] count
);

   localparam int QPW = $clog2(lpe_pkg::QUEUE_DEPTH);

   lpe_pkg::q_entry_type    entries_ff [lpe_pkg::QUEUE_DEPTH];
   logic [QPW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [lpe_pkg::QCW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(lpe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(lpe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + lpe_pkg::QCW'(1);
         2'b01:   count_in = count_ff - lpe_pkg::QCW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[rd_ptr_ff];
   assign count      = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < lpe_pkg::QCW'(lpe_pkg::QUEUE_DEPTH)) || pop)
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue underflow");

endmodule

/* sv/lpe_back.sv */
// -----------------------------------------------------------------------------
// lpe_back
// bit sequencer: unless rsp_stall holds, turns queued jobs into compare values, one per cycle
// -----------------------------------------------------------------------------
module lpe_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  lpe_pkg::q_entry_type head_entry,
   output logic                 pop,
   input  logic [7:0]           one_width,
   input  logic [7:0]           zero_width,
   input  logic [6:0]           tail_length,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_compare_value,
   output logic                 rsp_last
);

   logic                          active_ff, active_in;
   logic                          tail_ff, tail_in;
   logic [lpe_pkg::COLOR_W-1:0]   shift_ff, shift_in;
   logic [lpe_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_value_ff, rsp_value_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [lpe_pkg::CNT_W-1:0]     tail_cnt;
   logic                          out_free;
   logic                          emit;
   logic                          done;
   logic                          load;

   // remaining count minus one, tail length clamped to 1..64
   always_comb begin
      if (tail_length == '0) begin
         tail_cnt = '0;
      end else if (tail_length > 7'(lpe_pkg::TAIL_MAX)) begin
         tail_cnt = lpe_pkg::CNT_W'(lpe_pkg::TAIL_MAX - 1);
      end else begin
         tail_cnt = lpe_pkg::CNT_W'(tail_length - 7'd1);
      end
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign emit     = active_ff & out_free;
   assign done     = emit & (cnt_ff == '0);
   // next job starts in the cycle the current one sends its last value
   assign load     = head_valid & (~active_ff | done);
   assign pop      = load;

   always_comb begin
      active_in = active_ff;
      tail_in   = tail_ff;
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         active_in = 1'b1;
         tail_in   = head_entry.tail;
         shift_in  = head_entry.color;
         cnt_in    = head_entry.tail ? tail_cnt
                                     : lpe_pkg::CNT_W'(lpe_pkg::BITS_PER_PIXEL - 1);
      end else if (done) begin
         active_in = 1'b0;
      end else if (emit) begin
         shift_in = {shift_ff[lpe_pkg::COLOR_W-2:0], 1'b0};
         cnt_in   = cnt_ff - lpe_pkg::CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cnt_ff == '0;
         if (tail_ff) begin
            rsp_value_in = '0;
         end else begin
            rsp_value_in = shift_ff[lpe_pkg::COLOR_W-1] ? one_width : zero_width;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff      <= tail_in;
      shift_ff     <= shift_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_value_ff;
   assign rsp_last          = rsp_last_ff;

   a_result_from_job: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(active_ff))
      else $error("result produced with no job in progress");

endmodule

/* sv/led_pwm_bit_encoder_core.sv */
// -----------------------------------------------------------------------------
// led_pwm_bit_encoder_core
// palette based pwm bit encoder for a chain of addressable rgb leds
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   command, index, red, green, blue
//   rsp      out        rsp_valid/rsp_stall   compare_value, last
//   csr      in         csr_write_enable      csr_index, csr_write_data
//
// a pixel request gives 24 results, an end-of-frame request 1..64; the bit
// sequencer sends one result per cycle unless rsp_stall holds it, and starts
// the next job without a gap; requests queue up while a job is still sent.
// palette writes are absorbed while the sequencer runs, unless the queue is full.
// after reset a clearing pass zeroes the palette with req_stall held high;
// csr writes are taken throughout.
// a four-entry job queue and the result register let either side stall alone.
// -----------------------------------------------------------------------------
module led_pwm_bit_encoder_core #(
   parameter int PALETTE_DEPTH = lpe_pkg::PALETTE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_index,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_compare_value,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   logic [7:0]              one_width_ff, one_width_in;
   logic [7:0]              zero_width_ff, zero_width_in;
   logic [6:0]              tail_length_ff, tail_length_in;
   logic                    push;
   lpe_pkg::q_entry_type    push_entry;
   logic                    pop;
   logic                    head_valid;
   lpe_pkg::q_entry_type    head_entry;
   logic [lpe_pkg::QCW-1:0] q_count;

   always_comb begin
      one_width_in   = one_width_ff;
      zero_width_in  = zero_width_ff;
      tail_length_in = tail_length_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lpe_pkg::REG_ONE_WIDTH:   one_width_in   = csr_write_data;
            lpe_pkg::REG_ZERO_WIDTH:  zero_width_in  = csr_write_data;
            lpe_pkg::REG_TAIL_LENGTH: tail_length_in = csr_write_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_width_ff   <= lpe_pkg::ONE_WIDTH_RST;
         zero_width_ff  <= lpe_pkg::ZERO_WIDTH_RST;
         tail_length_ff <= lpe_pkg::TAIL_LENGTH_RST;
      end else begin
         one_width_ff   <= one_width_in;
         zero_width_ff  <= zero_width_in;
         tail_length_ff <= tail_length_in;
      end
   end

   lpe_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_index   (req_index),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .q_count     (q_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   lpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   lpe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .one_width         (one_width_ff),
      .zero_width        (zero_width_ff),
      .tail_length       (tail_length_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value),
      .rsp_last          (rsp_last)
   );

endmodule
